FILE: rtl/core/phtc_pkg.sv
`default_nettype none
package phtc_pkg;

  localparam int unsigned CountW = 63;

  localparam logic [2:0] FUNC_UP_PKT   = 3'd0;
  localparam logic [2:0] FUNC_DOWN_PKT = 3'd1;
  localparam logic [2:0] FUNC_RD_UP    = 3'd2;
  localparam logic [2:0] FUNC_RD_DOWN  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR    = 3'd4;

  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_IGNORED = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_VALID   = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  localparam logic CFG_LOCAL_ADDR  = 1'b0;
  localparam logic CFG_SUBNET_MASK = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic        wan_side;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] packet_length;
    logic [7:0]  slot_index;
  } phtc_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       host_address;
    logic [CountW-1:0] byte_count;
  } phtc_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/phtc_table.sv
`default_nettype none
module phtc_table import phtc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256,
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned FW = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [31:0]       rd_host_o,
  output logic      [CountW-1:0] rd_bytes_o,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [31:0]       wr_host_i,
  input  wire logic [CountW-1:0] wr_bytes_i,
  input  wire logic              alloc_i,
  input  wire logic              clear_i,
  output logic      [FW-1:0]     fill_o
);

  logic [31:0]       host_mem  [TABLE_ENTRIES];
  logic [CountW-1:0] bytes_mem [TABLE_ENTRIES];
  logic [FW-1:0]     fill_q, fill_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      host_mem[wr_addr_i]  <= wr_host_i;
      bytes_mem[wr_addr_i] <= wr_bytes_i;
    end
    if (rd_en_i) begin
      rd_host_o  <= host_mem[rd_addr_i];
      rd_bytes_o <= bytes_mem[rd_addr_i];
    end
  end

  // slots below the fill count are the valid ones
  always_comb begin
    fill_d = fill_q;
    if (clear_i) begin
      fill_d = '0;
    end else if (alloc_i) begin
      fill_d = fill_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign fill_o = fill_q;

endmodule
`default_nettype wire

FILE: rtl/core/per_host_traffic_counter.sv
`default_nettype none
// Per-host byte counters for upload and download, each table held in a
// synchronous memory. A packet item searches its table one slot at a
// time, reading each slot and then comparing it, up to the fill count,
// and allocates a new slot, if one is free, when the host is not found.
// One item is in work at a time; a finished result waits in the output
// register while the next is accepted.
module per_host_traffic_counter import phtc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire phtc_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output phtc_out_t        out_data_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_RDS  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [31:0] local_q, mask_q;
  logic        dir_q, dir_d;
  logic [31:0] host_q, host_d;
  logic [15:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d;
  phtc_out_t   res_q, res_d;
  phtc_out_t   out_q;
  logic        out_valid_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       up_rd_host, dn_rd_host, rd_host;
  logic [CountW-1:0] up_rd_bytes, dn_rd_bytes, rd_bytes;
  logic              wr_en, alloc, clear;
  logic [AW-1:0]     wr_addr;
  logic [CountW-1:0] wr_bytes;
  logic [FW-1:0]     up_fill, dn_fill, fill_sel, fill_in;

  logic              in_acc;
  logic              is_down_pkt;
  logic [31:0]       pkt_host;
  logic              pkt_ok;
  logic [16:0]       idx_ext;
  logic [16:0]       fill_ext;
  logic [CountW:0]   sum_hit, sum_new;
  logic [CountW-1:0] sat_hit, sat_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '0;
      mask_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_LOCAL_ADDR) begin
        local_q <= cfg_data_i;
      end else begin
        mask_q <= cfg_data_i;
      end
    end
  end

  phtc_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_up (
    .clk_i, .rst_ni,
    .rd_en_i(rd_en), .rd_addr_i(rd_addr),
    .rd_host_o(up_rd_host), .rd_bytes_o(up_rd_bytes),
    .wr_en_i(wr_en && !dir_q), .wr_addr_i(wr_addr),
    .wr_host_i(host_q), .wr_bytes_i(wr_bytes),
    .alloc_i(alloc && !dir_q), .clear_i(clear),
    .fill_o(up_fill)
  );

  phtc_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_down (
    .clk_i, .rst_ni,
    .rd_en_i(rd_en), .rd_addr_i(rd_addr),
    .rd_host_o(dn_rd_host), .rd_bytes_o(dn_rd_bytes),
    .wr_en_i(wr_en && dir_q), .wr_addr_i(wr_addr),
    .wr_host_i(host_q), .wr_bytes_i(wr_bytes),
    .alloc_i(alloc && dir_q), .clear_i(clear),
    .fill_o(dn_fill)
  );

  assign rd_host  = dir_q ? dn_rd_host : up_rd_host;
  assign rd_bytes = dir_q ? dn_rd_bytes : up_rd_bytes;
  assign fill_sel = dir_q ? dn_fill : up_fill;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_down_pkt = (in_data_i.func == FUNC_DOWN_PKT);
  assign pkt_host    = is_down_pkt ? in_data_i.dest_address : in_data_i.source_address;
  assign pkt_ok      = in_data_i.wan_side && (local_q != '0) && (mask_q != '0)
                       && (pkt_host != '0)
                       && ((local_q & mask_q) == (pkt_host & mask_q));
  assign idx_ext  = 17'(in_data_i.slot_index);
  assign fill_in  = (in_data_i.func == FUNC_RD_DOWN) ? dn_fill : up_fill;
  assign fill_ext = 17'(fill_in);

  // saturating add, for a hit and for a fresh slot
  assign sum_hit = {1'b0, rd_bytes} + (CountW+1)'(len_q);
  assign sat_hit = (sum_hit >= {1'b0, CountMax}) ? CountMax : sum_hit[CountW-1:0];
  assign sum_new = (CountW+1)'(len_q);
  assign sat_new = (sum_new >= {1'b0, CountMax}) ? CountMax : sum_new[CountW-1:0];

  always_comb begin
    state_d  = state_q;
    dir_d    = dir_q;
    host_d   = host_q;
    len_d    = len_q;
    idx_d    = idx_q;
    res_d    = res_q;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_bytes = sat_hit;
    alloc    = 1'b0;
    clear    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EMIT;
          res_d   = '{status: ST_IGNORED, host_address: '0, byte_count: '0};
          case (in_data_i.func)
            FUNC_UP_PKT, FUNC_DOWN_PKT: begin
              dir_d  = is_down_pkt;
              host_d = pkt_host;
              len_d  = in_data_i.packet_length;
              idx_d  = '0;
              if (pkt_ok) begin
                state_d = ((is_down_pkt ? dn_fill : up_fill) == '0) ? S_MISS : S_RD;
              end
            end
            FUNC_RD_UP, FUNC_RD_DOWN: begin
              dir_d = (in_data_i.func == FUNC_RD_DOWN);
              if (idx_ext < fill_ext) begin
                rd_en   = 1'b1;
                rd_addr = idx_ext[AW-1:0];
                state_d = S_RDS;
              end else begin
                res_d = '{status: ST_EMPTY, host_address: '0, byte_count: '0};
              end
            end
            FUNC_CLEAR: begin
              clear = 1'b1;
              res_d = '{status: ST_CLEARED, host_address: '0, byte_count: '0};
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rd_host == host_q) begin
          wr_en   = 1'b1;
          res_d   = '{status: ST_COUNTED, host_address: host_q, byte_count: sat_hit};
          state_d = S_EMIT;
        end else if ((FW'(idx_q) + FW'(1)) == fill_sel) begin
          state_d = S_MISS;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_RD;
        end
      end
      S_MISS: begin
        if (fill_sel >= FW'(TABLE_ENTRIES)) begin
          res_d = '{status: ST_FULL, host_address: host_q, byte_count: '0};
        end else begin
          wr_en    = 1'b1;
          wr_addr  = fill_sel[AW-1:0];
          wr_bytes = sat_new;
          alloc    = 1'b1;
          res_d    = '{status: ST_NEW, host_address: host_q, byte_count: sat_new};
        end
        state_d = S_EMIT;
      end
      S_RDS: begin
        res_d   = '{status: ST_VALID, host_address: rd_host, byte_count: rd_bytes};
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dir_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    host_q <= host_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: bench/tb_per_host_traffic_counter.sv
`timescale 1ns / 1ps
module tb_per_host_traffic_counter;
  import phtc_pkg::*;

  localparam int unsigned Entries = 256;
  localparam logic [62:0] CountMax = {63{1'b1}};

  class traffic_scoreboard;
    logic [31:0] lan_addr;
    logic [31:0] lan_mask;
    logic [31:0] host_tab [2][Entries];
    logic [62:0] bytes_tab [2][Entries];
    int unsigned fill [2];
    phtc_out_t pending_q [$];
    int unsigned mismatches;

    function new();
      lan_addr = '0;
      lan_mask = '0;
      fill[0] = 0;
      fill[1] = 0;
      mismatches = 0;
    endfunction

    function bit in_subnet(logic [31:0] a);
      if (lan_addr == 0 || lan_mask == 0 || a == 0) return 1'b0;
      return (lan_addr & lan_mask) == (a & lan_mask);
    endfunction

    function phtc_out_t count_bytes(int dir, logic [31:0] host, logic [15:0] len);
      phtc_out_t r;
      int slot;
      logic [62:0] cur;
      slot = -1;
      r = '0;
      r.status = ST_COUNTED;
      r.host_address = host;
      for (int i = 0; i < fill[dir]; i++) begin
        if (host_tab[dir][i] == host) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        if (fill[dir] >= Entries) begin
          r.status = ST_FULL;
          return r;
        end
        slot = fill[dir];
        fill[dir]++;
        host_tab[dir][slot] = host;
        bytes_tab[dir][slot] = '0;
        r.status = ST_NEW;
      end
      cur = bytes_tab[dir][slot];
      if (CountMax - cur > 63'(len)) cur = cur + 63'(len);
      else cur = CountMax;
      bytes_tab[dir][slot] = cur;
      r.byte_count = cur;
      return r;
    endfunction

    function void note_item(phtc_in_t it);
      phtc_out_t r;
      int dir;
      r = '0;
      r.status = ST_IGNORED;
      case (it.func)
        FUNC_UP_PKT: begin
          if (it.wan_side && in_subnet(it.source_address))
            r = count_bytes(0, it.source_address, it.packet_length);
        end
        FUNC_DOWN_PKT: begin
          if (it.wan_side && in_subnet(it.dest_address))
            r = count_bytes(1, it.dest_address, it.packet_length);
        end
        FUNC_RD_UP, FUNC_RD_DOWN: begin
          dir = (it.func == FUNC_RD_UP) ? 0 : 1;
          if (it.slot_index < fill[dir]) begin
            r.status = ST_VALID;
            r.host_address = host_tab[dir][it.slot_index];
            r.byte_count = bytes_tab[dir][it.slot_index];
          end else begin
            r.status = ST_EMPTY;
          end
        end
        FUNC_CLEAR: begin
          fill[0] = 0;
          fill[1] = 0;
          r.status = ST_CLEARED;
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(phtc_out_t got);
      phtc_out_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status || got.host_address !== exp_r.host_address ||
          got.byte_count !== exp_r.byte_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d host=%h cnt=%0d got st=%0d host=%h cnt=%0d",
                   exp_r.status, exp_r.host_address, exp_r.byte_count,
                   got.status, got.host_address, got.byte_count);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  phtc_in_t in_data;
  phtc_out_t out_data;
  traffic_scoreboard sb;

  per_host_traffic_counter u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random stalls, check on each accepted item
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 3) != 0);
      if (!out_ready) repeat (pick_gap()) @(negedge clk);
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // registers change only with no item in flight
  task automatic write_reg(logic idx, logic [31:0] val);
    while (sb.pending_q.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == CFG_LOCAL_ADDR) sb.lan_addr = val;
    else sb.lan_mask = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_item(phtc_in_t it, bit allow_gap);
    if (allow_gap) repeat (pick_gap()) @(negedge clk);
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic phtc_in_t make_item(logic [2:0] f, logic w, logic [31:0] s,
                                         logic [31:0] d, logic [15:0] l, logic [7:0] ix);
    phtc_in_t it;
    it.func = f;
    it.wan_side = w;
    it.source_address = s;
    it.dest_address = d;
    it.packet_length = l;
    it.slot_index = ix;
    return it;
  endfunction

  // host drawn from a small pool inside the subnet, sometimes outside
  function automatic logic [31:0] pick_host(int pool);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) return 32'h0;
    return (sb.lan_addr & sb.lan_mask) | (32'($urandom_range(1, pool)) & ~sb.lan_mask);
  endfunction

  task automatic random_phase(int n, int pool);
    phtc_in_t it;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      it = make_item(FUNC_UP_PKT, ($urandom_range(0, 9) != 0), pick_host(pool),
                     pick_host(pool), 16'($urandom()), 8'($urandom()));
      if (r < 40) it.func = FUNC_UP_PKT;
      else if (r < 80) it.func = FUNC_DOWN_PKT;
      else if (r < 88) it.func = FUNC_RD_UP;
      else if (r < 96) it.func = FUNC_RD_DOWN;
      else if (r < 98) it.func = 3'($urandom_range(5, 7));
      else it.func = FUNC_CLEAR;
      if (it.func == FUNC_RD_UP || it.func == FUNC_RD_DOWN)
        it.slot_index = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(0, pool));
      send_item(it, 1'b1);
    end
  endtask

  initial begin
    phtc_in_t it;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOCAL_ADDR;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // disabled counting, then directed cases
    send_item(make_item(FUNC_UP_PKT, 1'b1, 32'hC0A8_0105, 32'h0808_0808, 16'd100, 8'd0), 1'b0);
    write_reg(CFG_LOCAL_ADDR, 32'hC0A8_0101);
    send_item(make_item(FUNC_UP_PKT, 1'b1, 32'hC0A8_0105, 32'h0, 16'd100, 8'd0), 1'b0);
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_FF00);
    send_item(make_item(FUNC_UP_PKT, 1'b1, 32'hC0A8_0105, 32'h0, 16'hFFFF, 8'd0), 1'b0);
    send_item(make_item(FUNC_UP_PKT, 1'b1, 32'hC0A8_0105, 32'h0, 16'h0000, 8'd0), 1'b0);
    send_item(make_item(FUNC_UP_PKT, 1'b0, 32'hC0A8_0105, 32'h0, 16'd7, 8'd0), 1'b0);
    send_item(make_item(FUNC_UP_PKT, 1'b1, 32'h0A00_0001, 32'h0, 16'd7, 8'd0), 1'b0);
    send_item(make_item(FUNC_DOWN_PKT, 1'b1, 32'h0, 32'hC0A8_01FF, 16'd9, 8'd0), 1'b0);
    send_item(make_item(FUNC_DOWN_PKT, 1'b1, 32'h0, 32'hC0A8_01FF, 16'd1, 8'd0), 1'b0);
    send_item(make_item(FUNC_DOWN_PKT, 1'b1, 32'hFFFF_FFFF, 32'h0, 16'd1, 8'd0), 1'b0);
    send_item(make_item(FUNC_RD_UP, 1'b0, 32'h0, 32'h0, 16'h0, 8'd0), 1'b0);
    send_item(make_item(FUNC_RD_UP, 1'b1, '1, '1, '1, 8'd255), 1'b0);
    send_item(make_item(FUNC_RD_DOWN, 1'b0, 32'h0, 32'h0, 16'h0, 8'd0), 1'b0);
    send_item(make_item(FUNC_RD_DOWN, 1'b0, 32'h0, 32'h0, 16'h0, 8'd1), 1'b0);
    for (int f = 5; f < 8; f++)
      send_item(make_item(3'(f), 1'b1, 32'hC0A8_0105, 32'hC0A8_0105, 16'd3, 8'd0), 1'b0);
    send_item(make_item(FUNC_CLEAR, 1'b0, 32'h0, 32'h0, 16'h0, 8'd0), 1'b0);
    send_item(make_item(FUNC_RD_UP, 1'b0, 32'h0, 32'h0, 16'h0, 8'd0), 1'b0);
    drain();

    // fill the upload table, then overflow it
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_0000);
    for (int h = 1; h <= Entries + 2; h++)
      send_item(make_item(FUNC_UP_PKT, 1'b1, 32'hC0A8_0000 | 32'(h), 32'h0,
                          16'($urandom()), 8'd0), 1'b1);
    send_item(make_item(FUNC_UP_PKT, 1'b1, 32'hC0A8_0001, 32'h0, 16'hFFFF, 8'd0), 1'b0);
    send_item(make_item(FUNC_RD_UP, 1'b0, 32'h0, 32'h0, 16'h0, 8'd255), 1'b0);
    send_item(make_item(FUNC_CLEAR, 1'b0, 32'h0, 32'h0, 16'h0, 8'd0), 1'b0);
    drain();

    write_reg(CFG_LOCAL_ADDR, 32'hFFFF_FFFF);
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFFF);
    random_phase(60, 4);
    drain();
    write_reg(CFG_LOCAL_ADDR, 32'h0A00_0001);
    write_reg(CFG_SUBNET_MASK, 32'hFF00_0000);
    random_phase(140, 40);
    drain();
    write_reg(CFG_LOCAL_ADDR, $urandom() | 32'h1);
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFF0);
    random_phase(140, 15);
    drain();
    write_reg(CFG_LOCAL_ADDR, 32'h8000_0000);
    write_reg(CFG_SUBNET_MASK, 32'h8000_0000);
    random_phase(80, 200);
    drain();
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
